>>> design/cdsqg_pkg.sv
package cdsqg_pkg;

  localparam int unsigned LEAD_IN        = 150;
  localparam int unsigned FRAMES_PER_SEC = 75;
  localparam int unsigned SEC_PER_MIN    = 60;
  localparam int unsigned FRAMES_PER_MIN = 4500;
  // reciprocals: x/75 = (x*RECIP75)>>26 for x < 2^20, x/60 = (x*RECIP60)>>19 for x < 10000
  localparam logic [19:0] RECIP75     = 20'd894785;
  localparam logic [13:0] RECIP60     = 14'd8739;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam int unsigned Q_BYTES     = 12;
  localparam int unsigned CONV_PHASES = 5;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_ENTRY_COUNT   = 2'd0,
    CFG_CRC_INIT      = 2'd1,
    CFG_CRC_FINAL_XOR = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OUT_ACK,
    OUT_MISS,
    OUT_Q
  } out_kind_t;

  typedef struct packed {
    logic      wr_en;
    logic      query_load;
    logic      rd_en;
    logic      conv_en;
    logic [2:0] conv_phase;
    logic      conv_sel;
    logic      out_load;
    out_kind_t out_kind;
    logic [3:0] bi;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic pend;
    logic can_load;
  } status_t;

  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] p;
    logic [4:0]  t;
    logic [7:0]  o;
    p = 16'(v) * 16'd205;
    t = p[15:11];
    o = v - 8'(8'(t) * 8'd10);
    return {t[3:0], 4'b0000} + o;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

>>> design/cdsqg_if.sv
interface cdsqg_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [6:0]  entry_index;
  logic [7:0]  entry_point;
  logic [7:0]  entry_adr_ctl;
  logic [6:0]  entry_min;
  logic [5:0]  entry_sec;
  logic [6:0]  entry_frame;
  logic [18:0] lba;
  modport source (output valid, op, entry_index, entry_point, entry_adr_ctl, entry_min,
                  entry_sec, entry_frame, lba, input ready);
  modport sink (input valid, op, entry_index, entry_point, entry_adr_ctl, entry_min,
                entry_sec, entry_frame, lba, output ready);
endinterface

interface cdsqg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] q_byte;
  logic [3:0] byte_index;
  logic       last;
  logic       track_found;
  modport source (output valid, q_byte, byte_index, last, track_found, input ready);
  modport sink (input valid, q_byte, byte_index, last, track_found, output ready);
endinterface

interface cdsqg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

>>> design/cdsqg_ctrl.sv
module cdsqg_ctrl #(
  parameter int AW = 7,
  parameter int CW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  cdsqg_pkg::status_t  st,
  input  logic [CW-1:0]       count,
  output cdsqg_pkg::cmd_t     cmd,
  output logic [AW-1:0]       rd_addr
);

  cdsqg_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [3:0]    bi_r, bi_nxt;
  logic [CW-1:0] rem_m1;

  assign rem_m1  = rem_r - 1'b1;
  assign rd_addr = rem_m1[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdsqg_pkg::ST_IDLE: begin
        if (in_valid && st.can_load && in_op == cdsqg_pkg::OP_QUERY) state_nxt = cdsqg_pkg::ST_SEARCH;
      end
      cdsqg_pkg::ST_SEARCH: begin
        if (st.hit) state_nxt = cdsqg_pkg::ST_CONV;
        else if (rem_r == '0 && !st.pend && st.can_load) state_nxt = cdsqg_pkg::ST_IDLE;
      end
      cdsqg_pkg::ST_CONV: begin
        if (step_r == 4'(2 * cdsqg_pkg::CONV_PHASES - 1)) state_nxt = cdsqg_pkg::ST_EMIT;
      end
      cdsqg_pkg::ST_EMIT: begin
        if (st.can_load && bi_r == 4'(cdsqg_pkg::Q_BYTES - 1)) state_nxt = cdsqg_pkg::ST_IDLE;
      end
      default: state_nxt = cdsqg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.out_kind = cdsqg_pkg::OUT_ACK;
    rem_nxt  = rem_r;
    step_nxt = 4'd0;
    bi_nxt   = 4'd0;
    case (state_r)
      cdsqg_pkg::ST_IDLE: begin
        in_ready = st.can_load;
        if (in_valid && st.can_load) begin
          if (in_op == cdsqg_pkg::OP_WRITE) begin
            cmd.wr_en    = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_kind = cdsqg_pkg::OUT_ACK;
          end else begin
            cmd.query_load = 1'b1;
            rem_nxt        = count;
          end
        end
      end
      cdsqg_pkg::ST_SEARCH: begin
        if (!st.hit) begin
          if (rem_r != '0) begin
            cmd.rd_en = 1'b1;
            rem_nxt   = rem_m1;
          end else if (!st.pend && st.can_load) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = cdsqg_pkg::OUT_MISS;
          end
        end
      end
      cdsqg_pkg::ST_CONV: begin
        cmd.conv_en = 1'b1;
        if (step_r < 4'(cdsqg_pkg::CONV_PHASES)) begin
          cmd.conv_phase = 3'(step_r);
          cmd.conv_sel   = 1'b0;
        end else begin
          cmd.conv_phase = 3'(step_r - 4'(cdsqg_pkg::CONV_PHASES));
          cmd.conv_sel   = 1'b1;
        end
        step_nxt = step_r + 4'd1;
      end
      cdsqg_pkg::ST_EMIT: begin
        bi_nxt = bi_r;
        cmd.bi = bi_r;
        if (st.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = cdsqg_pkg::OUT_Q;
          bi_nxt       = bi_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdsqg_pkg::ST_IDLE;
      rem_r   <= '0;
      step_r  <= 4'd0;
      bi_r    <= 4'd0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      step_r  <= step_nxt;
      bi_r    <= bi_nxt;
    end
  end

endmodule

>>> design/cdsqg_dp.sv
module cdsqg_dp #(
  parameter int MAX_ENTRIES = 128,
  parameter int AW = 7,
  parameter int CW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cdsqg_pkg::cmd_t    cmd,
  input  logic [AW-1:0]      rd_addr,
  output cdsqg_pkg::status_t st,
  output logic [CW-1:0]      count,
  input  logic [6:0]         entry_index,
  input  logic [7:0]         entry_point,
  input  logic [7:0]         entry_adr_ctl,
  input  logic [6:0]         entry_min,
  input  logic [5:0]         entry_sec,
  input  logic [6:0]         entry_frame,
  input  logic [18:0]        lba,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_q_byte,
  output logic [3:0]         out_byte_index,
  output logic               out_last,
  output logic               out_track_found
);

  logic [7:0]  mem_point [MAX_ENTRIES];
  logic [7:0]  mem_ctl   [MAX_ENTRIES];
  logic [18:0] mem_start [MAX_ENTRIES];

  logic [7:0]  entry_count_r;
  logic [15:0] crc_init_r, crc_xor_r;

  logic [7:0]  rd_point_r, rd_ctl_r;
  logic [18:0] rd_start_r;
  logic        rd_vld_r;
  logic [19:0] abs_r;

  logic [7:0]  hit_point_r, hit_ctl_r;
  logic [19:0] diff_r;
  logic [15:0] crc_r;
  logic        idx0;

  logic [19:0] x_r, conv_in, rel_v;
  logic [39:0] p1_r;
  logic [13:0] q75_r;
  logic [27:0] p2_r;
  logic [6:0]  frm_r, min_r;
  logic [5:0]  sec_r;
  logic [7:0]  rel_m_r, rel_s_r, rel_f_r, abs_m_r, abs_s_r, abs_f_r;

  logic        out_vld_r;
  logic [7:0]  q_sel;
  logic [15:0] crc_out;
  logic [20:0] wr_frames;
  logic        wr_ok, hit;
  logic [8:0]  count_w;

  assign count_w = ({1'b0, entry_count_r} > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES)
                                                              : {1'b0, entry_count_r};
  assign count = CW'(count_w);

  assign wr_frames = 21'(entry_min) * 21'(cdsqg_pkg::FRAMES_PER_MIN)
                   + 21'(entry_sec) * 21'(cdsqg_pkg::FRAMES_PER_SEC) + 21'(entry_frame);
  assign wr_ok = 9'(entry_index) < 9'(MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem_point[AW'(entry_index)] <= entry_point;
      mem_ctl[AW'(entry_index)]   <= entry_adr_ctl;
      mem_start[AW'(entry_index)] <= wr_frames[18:0];
    end
    if (cmd.rd_en) begin
      rd_point_r <= mem_point[rd_addr];
      rd_ctl_r   <= mem_ctl[rd_addr];
      rd_start_r <= mem_start[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= 8'd0;
      crc_init_r    <= 16'hffff;
      crc_xor_r     <= 16'h0000;
    end else if (cfg_wr) begin
      case (cfg_addr)
        cdsqg_pkg::CFG_ENTRY_COUNT:   entry_count_r <= cfg_data[7:0];
        cdsqg_pkg::CFG_CRC_INIT:      crc_init_r    <= cfg_data;
        cdsqg_pkg::CFG_CRC_FINAL_XOR: crc_xor_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    hit = rd_vld_r && (rd_point_r inside {[8'd1:8'd99]}) && (abs_r >= 20'(rd_start_r));
  end

  assign st.hit      = hit;
  assign st.pend     = rd_vld_r;
  assign st.can_load = !out_vld_r || out_ready;

  assign idx0    = !hit_ctl_r[2] && (diff_r < 20'(cdsqg_pkg::LEAD_IN));
  assign rel_v   = idx0 ? (20'(cdsqg_pkg::LEAD_IN - 1) - diff_r) : diff_r;
  assign conv_in = cmd.conv_sel ? abs_r : rel_v;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= cmd.rd_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.query_load) abs_r <= 20'(lba) + 20'(cdsqg_pkg::LEAD_IN);
    if (hit) begin
      hit_point_r <= rd_point_r;
      hit_ctl_r   <= rd_ctl_r;
      diff_r      <= abs_r - 20'(rd_start_r);
    end
    if (cmd.conv_en) begin
      case (cmd.conv_phase)
        3'd0: begin
          x_r  <= conv_in;
          p1_r <= 40'(conv_in) * 40'(cdsqg_pkg::RECIP75);
        end
        3'd1: begin
          q75_r <= p1_r[39:26];
          frm_r <= 7'(21'(x_r) - 21'(p1_r[39:26]) * 21'(cdsqg_pkg::FRAMES_PER_SEC));
        end
        3'd2: p2_r <= 28'(q75_r) * 28'(cdsqg_pkg::RECIP60);
        3'd3: begin
          min_r <= p2_r[25:19];
          sec_r <= 6'(q75_r - 14'(p2_r[25:19]) * 14'(cdsqg_pkg::SEC_PER_MIN));
        end
        3'd4: begin
          if (cmd.conv_sel) begin
            abs_m_r <= cdsqg_pkg::to_bcd({1'b0, min_r});
            abs_s_r <= cdsqg_pkg::to_bcd({2'b00, sec_r});
            abs_f_r <= cdsqg_pkg::to_bcd({1'b0, frm_r});
          end else begin
            rel_m_r <= cdsqg_pkg::to_bcd({1'b0, min_r});
            rel_s_r <= cdsqg_pkg::to_bcd({2'b00, sec_r});
            rel_f_r <= cdsqg_pkg::to_bcd({1'b0, frm_r});
          end
        end
        default: ;
      endcase
    end
  end

  assign crc_out = crc_r ^ crc_xor_r;

  always_comb begin
    case (cmd.bi)
      4'd0:    q_sel = {hit_ctl_r[3:0], hit_ctl_r[7:4]};
      4'd1:    q_sel = cdsqg_pkg::to_bcd(hit_point_r);
      4'd2:    q_sel = {7'd0, !idx0};
      4'd3:    q_sel = rel_m_r;
      4'd4:    q_sel = rel_s_r;
      4'd5:    q_sel = rel_f_r;
      4'd7:    q_sel = abs_m_r;
      4'd8:    q_sel = abs_s_r;
      4'd9:    q_sel = abs_f_r;
      4'd10:   q_sel = crc_out[15:8];
      4'd11:   q_sel = crc_out[7:0];
      default: q_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hit) crc_r <= crc_init_r;
    else if (cmd.out_load && cmd.out_kind == cdsqg_pkg::OUT_Q && cmd.bi < 4'd10)
      crc_r <= cdsqg_pkg::crc_byte(crc_r, q_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        cdsqg_pkg::OUT_Q: begin
          out_q_byte      <= q_sel;
          out_byte_index  <= cmd.bi;
          out_last        <= (cmd.bi == 4'(cdsqg_pkg::Q_BYTES - 1));
          out_track_found <= 1'b1;
        end
        cdsqg_pkg::OUT_MISS: begin
          out_q_byte      <= 8'd0;
          out_byte_index  <= 4'd0;
          out_last        <= 1'b1;
          out_track_found <= 1'b0;
        end
        default: begin
          out_q_byte      <= 8'd0;
          out_byte_index  <= 4'd0;
          out_last        <= 1'b1;
          out_track_found <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_vld_r;

endmodule

>>> design/cd_subchannel_q_generator.sv
// CD subcode Q generator. A write item (op 0) stores one TOC entry (if entry_index is below
// MAX_ENTRIES) and answers with a single acknowledge item in the next cycle. A query item
// (op 1) scans the TOC entries below entry_count from last to first, one entry per cycle
// through the registered read port of the TOC memory, then runs the two MSF conversions
// and emits the 12 Q bytes (CRC included) one per cycle as the sink takes them. A query
// with no matching track answers with one zero item, track_found low. One item is
// processed at a time; configuration must be written while the block is idle, but the
// block itself does not enforce this.
module cd_subchannel_q_generator #(
  parameter int MAX_ENTRIES = 128
) (
  input logic         clk,
  input logic         rst_n,
  cdsqg_in_if.sink    in_ch,
  cdsqg_out_if.source out_ch,
  cdsqg_cfg_if.sink   cfg_ch
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  cdsqg_pkg::cmd_t    cmd;
  cdsqg_pkg::status_t st;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      count;

  assign cfg_ch.ready = 1'b1;

  cdsqg_ctrl #(.AW(AW), .CW(CW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .st       (st),
    .count    (count),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  cdsqg_dp #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW), .CW(CW)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .st              (st),
    .count           (count),
    .entry_index     (in_ch.entry_index),
    .entry_point     (in_ch.entry_point),
    .entry_adr_ctl   (in_ch.entry_adr_ctl),
    .entry_min       (in_ch.entry_min),
    .entry_sec       (in_ch.entry_sec),
    .entry_frame     (in_ch.entry_frame),
    .lba             (in_ch.lba),
    .cfg_wr          (cfg_ch.valid),
    .cfg_addr        (cfg_ch.addr),
    .cfg_data        (cfg_ch.data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_q_byte      (out_ch.q_byte),
    .out_byte_index  (out_ch.byte_index),
    .out_last        (out_ch.last),
    .out_track_found (out_ch.track_found)
  );

`ifndef SYNTHESIS
  a_wr_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == cdsqg_pkg::OP_WRITE)
      |=> (out_ch.valid && out_ch.last && out_ch.track_found))
    else $error("write item not acknowledged");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("input taken while result still pending");
  a_hit_once: assert property (@(posedge clk) disable iff (!rst_n)
    st.hit |=> !st.hit && !cmd.rd_en)
    else $error("search continued after hit");
`endif

endmodule
